// ===== sv/pcb_pkg.sv =====
// ============================================================================
// pcb_pkg
// Shared types and constants for the periodic counter bank: slot count,
// index width, action and status codes, and the flag command structure.
// ============================================================================
package pcb_pkg;

    localparam int SLOTS   = 8;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = 16;
    localparam int FIRED_W = 8;

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [SLOTS-1:0]  slot_vec_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_ADD    = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_START  = 3'd3,
        ACT_STOP   = 3'd4,
        ACT_READ   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_UNUSED = 2'd2
    } status_t;

    typedef struct packed {
        logic      claim;
        logic      claim_en;
        logic      release_slot;
        logic      set_en;
        logic      clr_en;
        slot_idx_t idx;
    } flag_cmd_t;

    typedef struct packed {
        logic      found;
        slot_idx_t idx;
    } free_slot_t;

endpackage

// ===== sv/periodic_counter_bank.sv =====
// ============================================================================
// periodic_counter_bank
// Bank of periodic tick counters. Counts and targets live in two RAMs; a
// tick scans one slot per cycle, reading, incrementing and writing back active slots.
// ============================================================================
// Sequence: add, delete, start, stop and unknown actions go from idle straight
// to the done state; a read passes through the read state, a tick through the
// scan state, which visits one slot per cycle. A new word is taken only in idle,
// once the done state has handed the previous result to the output register.
// Reset: synchronous, active low; clears the slot flags, the sequencer and
// the output valid. The RAMs are not cleared, since every add writes its slot.
module periodic_counter_bank (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // slot[2:0], period_target[18:3], start_enabled[19]
    input  logic [2:0]  s_tuser,  // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // given_slot[2:0], count_value[18:3], fired_mask[26:19]
    output logic [1:0]  m_tuser   // status[1:0]
);
    import pcb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_READ = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic         accept;
    action_t      in_action;
    logic [2:0]   in_slot;
    cnt_t         in_target;
    logic         in_start;
    slot_idx_t    slot_idx;
    logic         slot_ok;

    slot_vec_t    used;
    slot_vec_t    enabled;
    free_slot_t   free_slot;
    flag_cmd_t    flag_cmd;

    logic         cnt_we;
    slot_idx_t    cnt_waddr;
    cnt_t         cnt_wdata;
    slot_idx_t    raddr;
    cnt_t         cnt_rdata;
    cnt_t         tgt_rdata;
    logic         tgt_we;

    slot_idx_t    scan_idx_reg, scan_idx_next;
    logic         scan_active;
    cnt_t         scan_inc;
    logic         scan_hit;

    status_t      res_status_reg, res_status_next;
    logic [2:0]   res_given_reg, res_given_next;
    cnt_t         res_count_reg, res_count_next;
    logic [FIRED_W-1:0] res_fired_reg, res_fired_next;

    logic         m_valid_reg, m_valid_next;
    logic [31:0]  m_data_reg, m_data_next;
    status_t      m_user_reg, m_user_next;
    logic         out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_action = action_t'(s_tuser);
    assign in_slot   = s_tdata[2:0];
    assign in_target = s_tdata[18:3];
    assign in_start  = s_tdata[19];
    assign slot_idx  = SLOT_W'(in_slot);
    assign slot_ok   = (32'(in_slot) < 32'(SLOTS)) && used[slot_idx];
    assign out_free  = !m_valid_reg || m_tready;

    pcb_flags u_flags (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (flag_cmd),
        .used      (used),
        .enabled   (enabled),
        .free_slot (free_slot)
    );

    pcb_ram #(.WIDTH(CNT_W), .DEPTH(SLOTS)) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (raddr),
        .rdata (cnt_rdata)
    );

    pcb_ram #(.WIDTH(CNT_W), .DEPTH(SLOTS)) u_target_ram (
        .aclk  (aclk),
        .we    (tgt_we),
        .waddr (free_slot.idx),
        .wdata (in_target),
        .raddr (raddr),
        .rdata (tgt_rdata)
    );

    // Slot whose count and target are on the RAM outputs during a scan.
    assign scan_active = used[scan_idx_reg] && enabled[scan_idx_reg];
    assign scan_inc    = cnt_rdata + cnt_t'(1);
    assign scan_hit    = (scan_inc >= tgt_rdata);

    always_comb begin
        if (state_reg == ST_IDLE) begin
            raddr = (in_action == ACT_TICK) ? '0 : slot_idx;
        end else begin
            raddr = SLOT_W'(scan_idx_reg + slot_idx_t'(1));
        end
    end

    always_comb begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        res_status_next = res_status_reg;
        res_given_next  = res_given_reg;
        res_count_next  = res_count_reg;
        res_fired_next  = res_fired_reg;
        flag_cmd        = '0;
        flag_cmd.idx    = slot_idx;
        cnt_we          = 1'b0;
        cnt_waddr       = slot_idx;
        cnt_wdata       = '0;
        tgt_we          = 1'b0;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_status_next = STAT_OK;
                    res_given_next  = '0;
                    res_count_next  = '0;
                    res_fired_next  = '0;
                    state_next      = ST_DONE;
                    case (in_action)
                        ACT_TICK: begin
                            scan_idx_next = '0;
                            state_next    = ST_SCAN;
                        end
                        ACT_ADD: begin
                            if (free_slot.found) begin
                                flag_cmd.claim    = 1'b1;
                                flag_cmd.claim_en = in_start;
                                cnt_we            = 1'b1;
                                cnt_waddr         = free_slot.idx;
                                tgt_we            = 1'b1;
                                res_given_next    = 3'(free_slot.idx);
                            end else begin
                                res_status_next = STAT_FULL;
                            end
                        end
                        ACT_DELETE: begin
                            if (slot_ok) begin
                                flag_cmd.release_slot = 1'b1;
                            end else begin
                                res_status_next = STAT_UNUSED;
                            end
                        end
                        ACT_START: begin
                            if (slot_ok) begin
                                flag_cmd.set_en = 1'b1;
                            end else begin
                                res_status_next = STAT_UNUSED;
                            end
                        end
                        ACT_STOP: begin
                            if (slot_ok) begin
                                flag_cmd.clr_en = 1'b1;
                                cnt_we          = 1'b1;
                            end else begin
                                res_status_next = STAT_UNUSED;
                            end
                        end
                        ACT_READ: begin
                            if (!slot_ok) begin
                                res_status_next = STAT_UNUSED;
                            end
                            state_next = ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_active) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = scan_idx_reg;
                    cnt_wdata = scan_hit ? '0 : scan_inc;
                    if (scan_hit && (32'(scan_idx_reg) < 32'(FIRED_W))) begin
                        res_fired_next[3'(scan_idx_reg)] = 1'b1;
                    end
                end
                scan_idx_next = SLOT_W'(scan_idx_reg + slot_idx_t'(1));
                if (32'(scan_idx_reg) == 32'(SLOTS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_READ: begin
                if (res_status_reg == STAT_OK) begin
                    res_count_next = cnt_rdata;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'b0, res_fired_reg, res_count_reg, res_given_reg};
                    m_user_next  = res_status_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        scan_idx_reg   <= scan_idx_next;
        res_status_reg <= res_status_next;
        res_given_reg  <= res_given_next;
        res_count_reg  <= res_count_next;
        res_fired_reg  <= res_fired_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== sv/pcb_ram.sv =====
// ============================================================================
// pcb_ram
// Generic simple dual-port RAM with one write port and one registered
// read port.
// ============================================================================
module pcb_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/pcb_flags.sv =====
// ============================================================================
// pcb_flags
// In-use and enable flags of every slot, with the search for the lowest
// free slot used by an add.
// ============================================================================
module pcb_flags (
    input  logic                aclk,
    input  logic                aresetn,
    input  pcb_pkg::flag_cmd_t  cmd,
    output pcb_pkg::slot_vec_t  used,
    output pcb_pkg::slot_vec_t  enabled,
    output pcb_pkg::free_slot_t free_slot
);
    import pcb_pkg::*;

    slot_vec_t  used_reg, used_next;
    slot_vec_t  en_reg, en_next;
    free_slot_t free_c;

    always_comb begin
        free_c = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_c.found = 1'b1;
                free_c.idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        used_next = used_reg;
        en_next   = en_reg;
        if (cmd.claim && free_c.found) begin
            used_next[free_c.idx] = 1'b1;
            en_next[free_c.idx]   = cmd.claim_en;
        end
        if (cmd.release_slot) begin
            used_next[cmd.idx] = 1'b0;
            en_next[cmd.idx]   = 1'b0;
        end
        if (cmd.set_en) begin
            en_next[cmd.idx] = 1'b1;
        end
        if (cmd.clr_en) begin
            en_next[cmd.idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            en_reg   <= '0;
        end else begin
            used_reg <= used_next;
            en_reg   <= en_next;
        end
    end

    assign used      = used_reg;
    assign enabled   = en_reg;
    assign free_slot = free_c;

endmodule
